// ===== rtl/swr_pkg.sv =====
// Package for the sliding-window RMS block: widths, limits and the control
// structs passed between the sequencer and the divide/root unit.
// No dependencies.
package swr_pkg;

   localparam int WINDOW_MAX  = 256;
   localparam int SAMPLE_BITS = 16;
   localparam int WIN_BITS    = 9;
   localparam int RMS_BITS    = 16;

   localparam int ADDR_BITS = $clog2(WINDOW_MAX);
   localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int SQ_BITS   = 2 * SAMPLE_BITS - 1;
   localparam int SUM_BITS  = SQ_BITS + ADDR_BITS;
   localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 3;
   localparam int CNT_BITS  = $clog2(SUM_BITS + 1);

   localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(256);

   typedef struct packed {
      logic                start;
      logic [LEN_BITS-1:0] divisor;
   } arith_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } arith_stat_type;

endpackage

// ===== rtl/swr_ring.sv =====
// Square ring storage: one write port, one registered read port.
// Depends on swr_pkg.
module swr_ring (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [swr_pkg::ADDR_BITS-1:0] wr_addr,
   input  logic [swr_pkg::SQ_BITS-1:0]   wr_data,
   input  logic [swr_pkg::ADDR_BITS-1:0] rd_addr,
   output logic [swr_pkg::SQ_BITS-1:0]   rd_data
);
   import swr_pkg::*;

   logic [SQ_BITS-1:0] mem [WINDOW_MAX];
   logic [SQ_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swr_arith.sv =====
// Iterative divide-then-square-root unit built around one shared
// compare/subtract: restoring divide one bit per cycle, then root one bit per cycle.
// Depends on swr_pkg.
module swr_arith (
   input  logic                         clock,
   input  logic                         reset,
   input  swr_pkg::arith_cmd_type        cmd,
   input  logic [swr_pkg::SUM_BITS-1:0] dividend,
   output swr_pkg::arith_stat_type       stat
);
   import swr_pkg::*;

   typedef enum logic [1:0] {A_IDLE, A_DIV, A_SQRT, A_DONE} state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [RAD_BITS-1:0]  work_ff, work_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [LEN_BITS-1:0]  divisor_ff, divisor_in;

   logic [REM_BITS-1:0]  opa, opb;
   logic [REM_BITS:0]    diff;
   logic                 ge;

   // shared compare/subtract
   always_comb begin
      if (state_ff == A_SQRT) begin
         opa = {rem_ff[REM_BITS-3:0], work_ff[RAD_BITS-1 -: 2]};
         opb = REM_BITS'({root_ff, 2'b01});
      end else begin
         opa = REM_BITS'({rem_ff[LEN_BITS-1:0], work_ff[SUM_BITS-1]});
         opb = REM_BITS'(divisor_ff);
      end
      diff = {1'b0, opa} - {1'b0, opb};
      ge   = ~diff[REM_BITS];
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (cmd.start) begin
               work_in    = RAD_BITS'(dividend);
               divisor_in = cmd.divisor;
               rem_in     = '0;
               cnt_in     = CNT_BITS'(SUM_BITS - 1);
               state_in   = A_DIV;
            end
         end
         A_DIV: begin
            rem_in  = ge ? diff[REM_BITS-1:0] : opa;
            work_in = {{(RAD_BITS - SUM_BITS){1'b0}}, work_ff[SUM_BITS-2:0], ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rem_in   = '0;
               root_in  = '0;
               cnt_in   = CNT_BITS'(ROOT_BITS - 1);
               state_in = A_SQRT;
            end
         end
         A_SQRT: begin
            rem_in  = ge ? diff[REM_BITS-1:0] : opa;
            work_in = {work_ff[RAD_BITS-3:0], 2'b00};
            root_in = {root_ff[ROOT_BITS-2:0], ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = A_DONE;
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff     <= cnt_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
   end

   assign stat.done = (state_ff == A_DONE);
   assign stat.root = root_ff;

endmodule

// ===== rtl/sliding_window_rms.sv =====
// Sliding-window RMS top level: sequencer, pointers, running sum and output register.
// Depends on swr_pkg, swr_ring and swr_arith.
//
// Each sample word passes through squaring, ring update and unit start, the bit-serial
// divide of the 39-bit sum by the window length, the bit-serial square root, the done
// handoff and the load of the output register. req_stall stays high until the result
// is loaded, so a word enters only after the previous result is loaded, and later if
// the result before it still waits in the output register. Both iterations run on one
// shared compare/subtract unit; the output register lets the next word enter while the
// result waits. A csr write sets the window length (0 reads as 1, above 256 as 256)
// and restarts the window; while csr_valid is high req_stall is held high, and the
// window length should be written only while no word is in flight.
module sliding_window_rms (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [swr_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [swr_pkg::RMS_BITS-1:0]           rsp_rms_level,
   output logic                                   rsp_window_full,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [swr_pkg::WIN_BITS-1:0]           csr_window_length
);
   import swr_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SQUARE, S_UPDATE, S_START, S_CALC, S_EMIT}
      state_type;

   state_type            state_ff, state_in;
   logic [WIN_BITS-1:0]  window_ff, window_in;
   logic [ADDR_BITS-1:0] wp_ff, wp_in, op_ff, op_in;
   logic [LEN_BITS-1:0]  fill_ff, fill_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SQ_BITS-1:0]   sq_ff, sq_in;
   logic                 full_ff, full_in;
   logic                 full_out_ff, full_out_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RMS_BITS-1:0]  rms_ff, rms_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic [LEN_BITS-1:0]  len;
   logic [LEN_BITS-1:0]  wp_p1, op_p1, fill_after;
   logic [SAMPLE_BITS-1:0] mag;
   logic [2*SAMPLE_BITS-1:0] prod;
   logic [SQ_BITS-1:0]   rd_data;
   logic [SQ_BITS-1:0]   leaving;
   logic                 ring_wr;
   logic                 in_accept, csr_accept, out_free;
   arith_cmd_type        cmd;
   arith_stat_type       stat;

   swr_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (wp_ff),
      .wr_data (sq_ff),
      .rd_addr (op_ff),
      .rd_data (rd_data)
   );

   swr_arith u_arith (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .dividend (sum_ff),
      .stat     (stat)
   );

   always_comb begin
      if (window_ff == '0) begin
         len = LEN_BITS'(1);
      end else if (LEN_BITS'(window_ff) > LEN_BITS'(WINDOW_MAX)) begin
         len = LEN_BITS'(WINDOW_MAX);
      end else begin
         len = LEN_BITS'(window_ff);
      end
      wp_p1      = LEN_BITS'(wp_ff) + 1'b1;
      op_p1      = LEN_BITS'(op_ff) + 1'b1;
      fill_after = full_ff ? fill_ff : fill_ff + 1'b1;
      mag        = sample_ff[SAMPLE_BITS-1] ? (~sample_ff + 1'b1) : sample_ff;
      prod       = mag * mag;
      leaving    = full_ff ? rd_data : '0;
   end

   assign in_accept   = req_valid & ~req_stall;
   assign csr_accept  = csr_valid & csr_ready;
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign ring_wr     = (state_ff == S_UPDATE);
   assign cmd.start   = (state_ff == S_START);
   assign cmd.divisor = len;

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      wp_in        = wp_ff;
      op_in        = op_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      sq_in        = sq_ff;
      full_in      = full_ff;
      full_out_in  = full_out_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rms_in       = rms_ff;
      rsp_full_in  = rsp_full_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_accept) begin
               window_in = csr_window_length;
               wp_in     = '0;
               op_in     = '0;
               fill_in   = '0;
               sum_in    = '0;
            end else if (in_accept) begin
               sample_in = req_sample;
               full_in   = (fill_ff == len);
               state_in  = S_SQUARE;
            end
         end
         S_SQUARE: begin
            sq_in    = prod[SQ_BITS-1:0];
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            sum_in      = sum_ff + SUM_BITS'(sq_ff) - SUM_BITS'(leaving);
            wp_in       = (wp_p1 >= len) ? '0 : wp_p1[ADDR_BITS-1:0];
            if (full_ff) begin
               op_in = (op_p1 >= len) ? '0 : op_p1[ADDR_BITS-1:0];
            end
            fill_in     = fill_after;
            full_out_in = (fill_after == len);
            state_in    = S_START;
         end
         S_START: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (stat.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rms_in       = stat.root[RMS_BITS-1:0];
               rsp_full_in  = full_out_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_RESET;
         wp_ff        <= '0;
         op_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wp_ff        <= wp_in;
         op_ff        <= op_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      sq_ff       <= sq_in;
      full_ff     <= full_in;
      full_out_ff <= full_out_in;
      rms_ff      <= rms_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign req_stall       = (state_ff != S_IDLE) | csr_valid;
   assign csr_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rms_level   = rms_ff;
   assign rsp_window_full = rsp_full_ff;

endmodule

// ===== rtl/swr_checker.sv =====
// Port-level checks for sliding_window_rms, attached by bind.
// Depends on swr_pkg and sliding_window_rms.
module swr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [swr_pkg::RMS_BITS-1:0] rsp_rms_level,
   input logic                         rsp_window_full,
   input logic                         csr_valid,
   input logic                         csr_ready
);
   import swr_pkg::*;

   localparam logic [RMS_BITS-1:0] RMS_LIMIT = RMS_BITS'(1 << (SAMPLE_BITS - 1));

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rms_level)
         && $stable(rsp_window_full))
      else $error("stalled result word changed");

   // accepted word keeps the block busy and cannot yield a result at once
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !$rose(rsp_valid))
      else $error("block not busy after accepting a word");

   // input side open only when the config port is open and not being written
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> csr_ready && !csr_valid)
      else $error("input open while csr busy or written");

   // a mean of squares of samples never exceeds the largest magnitude squared
   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_rms_level <= RMS_LIMIT)
      else $error("rms level out of range");

endmodule

bind sliding_window_rms swr_checker u_swr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_rms_level   (rsp_rms_level),
   .rsp_window_full (rsp_window_full),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);
